FILE: rtl/core/bpp_pkg.sv
// bpp_pkg: shared types and constants for the biosignal packet parser
// depends on nothing; used by the parse core, the result queue and the top level
`default_nettype none

package bpp_pkg;

   localparam logic [7:0] FOOTER_BYTE = 8'hC0;
   localparam logic [7:0] HEADER_BYTE = 8'hA0;

   typedef enum logic [1:0] {
      KIND_CHANNEL   = 2'd0,
      KIND_FRAME_END = 2'd1,
      KIND_RESYNC    = 2'd2
   } result_kind_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [2:0]         channel_index;
      logic signed [23:0] sample_value;
      logic [7:0]         sample_number;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/core/bpp_ifs.sv
// bpp_req_if and bpp_rsp_if: valid/ready channels carrying received bytes and parse results
// depends on nothing
`default_nettype none

interface bpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface bpp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic [2:0]         channel_index;
   logic signed [23:0] sample_value;
   logic [7:0]         sample_number;

   modport source (output valid, output result_kind, output channel_index,
                   output sample_value, output sample_number, input ready);
   modport sink (input valid, input result_kind, input channel_index,
                 input sample_value, input sample_number, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bpp_parse_core.sv
// bpp_parse_core: frame state machine, updates parser state for one byte and forms its result
// depends on bpp_pkg
`default_nettype none

module bpp_parse_core #(
   parameter int ADC_CHANNELS = 8,
   parameter int ACCEL_AXES   = 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               byte_valid,
   input  wire logic [7:0]         rx_byte,
   output logic                    result_valid,
   output bpp_pkg::result_type     result
);

   typedef enum logic [2:0] {
      PH_HUNT         = 3'd0,
      PH_AFTER_FOOTER = 3'd1,
      PH_SAMPLE_NUM   = 3'd2,
      PH_CHANNEL      = 3'd3,
      PH_ACCEL        = 3'd4,
      PH_FOOTER       = 3'd5
   } phase_type;

   localparam logic [3:0] LAST_CHANNEL = 4'(ADC_CHANNELS - 1);
   localparam logic [3:0] LAST_AXIS    = 4'((ACCEL_AXES > 0) ? ACCEL_AXES - 1 : 0);

   phase_type   phase_ff, phase_in;
   logic [7:0]  frame_number_ff, frame_number_in;
   logic [3:0]  field_index_ff, field_index_in;
   logic [1:0]  byte_index_ff, byte_index_in;
   logic [23:0] value_acc_ff, value_acc_in;
   logic [23:0] value_shifted;

   assign value_shifted = {value_acc_ff[15:0], rx_byte};

   always_comb begin
      phase_in        = phase_ff;
      frame_number_in = frame_number_ff;
      field_index_in  = field_index_ff;
      byte_index_in   = byte_index_ff;
      value_acc_in    = value_acc_ff;
      result_valid    = 1'b0;
      result          = '0;
      result.sample_number = frame_number_ff;
      case (phase_ff)
         PH_AFTER_FOOTER: begin
            phase_in = (rx_byte == bpp_pkg::HEADER_BYTE) ? PH_SAMPLE_NUM : PH_HUNT;
         end
         PH_SAMPLE_NUM: begin
            frame_number_in = rx_byte;
            field_index_in  = '0;
            byte_index_in   = '0;
            value_acc_in    = '0;
            phase_in        = PH_CHANNEL;
         end
         PH_CHANNEL: begin
            if (byte_index_ff == 2'd2) begin
               result_valid         = 1'b1;
               result.result_kind   = bpp_pkg::KIND_CHANNEL;
               result.channel_index = field_index_ff[2:0];
               result.sample_value  = value_shifted;
               byte_index_in        = '0;
               value_acc_in         = '0;
               if (field_index_ff == LAST_CHANNEL) begin
                  field_index_in = '0;
                  phase_in       = (ACCEL_AXES > 0) ? PH_ACCEL : PH_FOOTER;
               end else begin
                  field_index_in = field_index_ff + 4'd1;
               end
            end else begin
               byte_index_in = byte_index_ff + 2'd1;
               value_acc_in  = value_shifted;
            end
         end
         PH_ACCEL: begin
            if (byte_index_ff == 2'd1) begin
               byte_index_in = '0;
               if (field_index_ff >= LAST_AXIS) begin
                  field_index_in = '0;
                  phase_in       = PH_FOOTER;
               end else begin
                  field_index_in = field_index_ff + 4'd1;
               end
            end else begin
               byte_index_in = byte_index_ff + 2'd1;
            end
         end
         PH_FOOTER: begin
            result_valid       = 1'b1;
            result.result_kind = (rx_byte == bpp_pkg::FOOTER_BYTE) ?
                                 bpp_pkg::KIND_FRAME_END : bpp_pkg::KIND_RESYNC;
            phase_in           = PH_HUNT;
         end
         default: begin
            if (rx_byte == bpp_pkg::FOOTER_BYTE) begin
               phase_in = PH_AFTER_FOOTER;
            end else if (rx_byte == bpp_pkg::HEADER_BYTE) begin
               phase_in = PH_SAMPLE_NUM;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
      if (!byte_valid) begin
         result_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         frame_number_ff <= '0;
         field_index_ff  <= '0;
         byte_index_ff   <= '0;
         value_acc_ff    <= '0;
      end else if (byte_valid) begin
         phase_ff        <= phase_in;
         frame_number_ff <= frame_number_in;
         field_index_ff  <= field_index_in;
         byte_index_ff   <= byte_index_in;
         value_acc_ff    <= value_acc_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/bpp_rsp_queue.sv
// bpp_rsp_queue: two-entry result queue that decouples the parser from the result channel
// depends on bpp_pkg
`default_nettype none

module bpp_rsp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire bpp_pkg::result_type push_data,
   input  wire logic                pop,
   output logic                     head_valid,
   output bpp_pkg::result_type      head_data,
   output logic [1:0]               count
);

   bpp_pkg::result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/biosignal_packet_parser.sv
// biosignal_packet_parser: top level, byte input register, parse core and result queue
// depends on bpp_pkg, bpp_ifs, bpp_parse_core and bpp_rsp_queue
`default_nettype none

// Takes one received byte per request and parses the biosignal packet stream: header 0xA0
// (alone or after a 0xC0 footer), sample-number byte, ADC_CHANNELS big-endian 24-bit channel
// values (each reported with its index and the sample number), ACCEL_AXES two-byte
// accelerometer values (consumed silently) and a footer check reported as a clean frame end
// or a resync. A byte is accepted every cycle while the result channel keeps up; its result
// passes through the byte register and then the two-entry result queue before it is offered
// on the result channel. The request side stalls whenever the byte register and the queue
// together hold two entries and the result channel is not taking one in that cycle.
module biosignal_packet_parser #(
   parameter int ADC_CHANNELS = 8,
   parameter int ACCEL_AXES   = 3
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bpp_req_if.sink    req_chan,
   bpp_rsp_if.source  rsp_chan
);

   logic                byte_valid_ff, byte_valid_in;
   logic [7:0]          byte_ff;
   logic                result_valid;
   bpp_pkg::result_type result;
   logic                pop;
   logic                head_valid;
   bpp_pkg::result_type head_data;
   logic [1:0]          queue_count;
   logic [2:0]          occupancy;
   logic                req_accept;

   assign pop        = head_valid & rsp_chan.ready;
   assign occupancy  = {1'b0, queue_count} + {2'b00, byte_valid_ff} - {2'b00, pop};
   assign req_chan.ready = (occupancy < 3'd2);
   assign req_accept = req_chan.valid & req_chan.ready;
   assign byte_valid_in = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         byte_ff <= req_chan.rx_byte;
      end
   end

   bpp_parse_core #(
      .ADC_CHANNELS (ADC_CHANNELS),
      .ACCEL_AXES   (ACCEL_AXES)
   ) u_parse_core (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (byte_valid_ff),
      .rx_byte      (byte_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   bpp_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (result_valid),
      .push_data  (result),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .count      (queue_count)
   );

   assign rsp_chan.valid         = head_valid;
   assign rsp_chan.result_kind   = head_data.result_kind;
   assign rsp_chan.channel_index = head_data.channel_index;
   assign rsp_chan.sample_value  = head_data.sample_value;
   assign rsp_chan.sample_number = head_data.sample_number;

endmodule

`default_nettype wire
